>>> src/huffman_code_table_bit_packer_assert.svh
// Assertion macros for the Huffman code table bit packer.
// Used by the top level; depends on nothing else.
`ifndef HUFFMAN_CODE_TABLE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_TABLE_BIT_PACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HCBP_ASSERT_NOW(name, clock, reset_n, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("hcbp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(name, clock, reset_n, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error("hcbp: next-cycle check failed");

`endif

>>> src/hcbp_pkg.sv
// Shared types and constants for the Huffman code table bit packer.
// Depends on nothing; used by every module of the block.
`default_nettype none

package hcbp_pkg;

    localparam int MAX_CODE_BITS = 32;
    localparam int SYMBOL_COUNT  = 256;
    localparam int BYTE_BITS     = 8;

    localparam int KIND_W = 2;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int USED_W = 4;
    localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_length;
    } item_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic [USED_W-1:0]    bits_used;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic load_wr;
        logic lookup;
        logic align;
        logic step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic fills;
        logic pending;
        logic out_ready;
    } status_t;

endpackage

`default_nettype wire

>>> src/huffman_code_table_bit_packer.sv
// A load writes the table and the next transaction may follow at once. An
// encode reads its table entry, aligns the code and then packs one byte per
// cycle while results are taken; no new item is accepted until it is done.
// A flush emits any partial byte once the result register is free. Rate is set
// by the packing step, which completes at most one byte per cycle.
// Reset clears the packer and control state; the code table is not cleared.
`default_nettype none

`include "huffman_code_table_bit_packer_assert.svh"

module huffman_code_table_bit_packer
    import hcbp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    output logic       result_valid,
    input  wire logic  result_stall,
    output result_t    result
);

    cmd_t    cmd;
    status_t status;

    hcbp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_kind  (item.kind),
        .status     (status),
        .cmd        (cmd)
    );

    hcbp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `HCBP_ASSERT_NOW(a_emit_into_free_slot, clk, rst_n, cmd.step && status.fills, status.out_ready)
    `HCBP_ASSERT_NOW(a_partial_is_last, clk, rst_n,
        result_valid && (result.bits_used != USED_W'(BYTE_BITS)), result.last)
    `HCBP_ASSERT_NEXT(a_lookup_then_align, clk, rst_n, cmd.lookup, cmd.align)
    `HCBP_ASSERT_NEXT(a_flush_clears, clk, rst_n, cmd.flush, !status.pending)

endmodule

`default_nettype wire

>>> src/hcbp_datapath.sv
// Datapath of the bit packer: code table memory, code alignment, byte packing
// and the result register. Depends on hcbp_pkg; driven by hcbp_ctrl.
`default_nettype none

module hcbp_datapath
    import hcbp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire item_t   item,
    input  wire cmd_t    cmd,
    output status_t      status,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_CODE_BITS);
    localparam logic [LEN_W-1:0]  BYTE_LEN  = LEN_W'(BYTE_BITS);
    localparam logic [USED_W-1:0] BYTE_USED = USED_W'(BYTE_BITS);

    logic [MAX_CODE_BITS+LEN_W-1:0] mem [SYMBOL_COUNT];
    logic [MAX_CODE_BITS-1:0]       rd_code_reg;
    logic [LEN_W-1:0]               rd_len_reg;
    logic                           rd_ok_reg;

    logic [MAX_CODE_BITS-1:0] aligned_reg, aligned_next;
    logic [LEN_W-1:0]         rem_reg, rem_next;
    logic [BYTE_BITS-1:0]     partial_reg, partial_next;
    logic [USED_W-1:0]        free_reg, free_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;

    logic                 sym_ok;
    logic [ADDR_W-1:0]    addr;
    logic [LEN_W-1:0]     len_sat;
    logic [BYTE_BITS-1:0] chunk;
    logic [BYTE_BITS-1:0] placed;
    logic [BYTE_BITS-1:0] byte_val;
    logic [USED_W-1:0]    right_shift;
    logic [LEN_W-1:0]     rem_after;
    logic                 out_ready;
    logic                 fills;
    logic                 pending;
    logic                 out_taken;

    assign sym_ok  = {1'b0, item.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
    assign addr    = item.symbol[ADDR_W-1:0];
    assign len_sat = (item.code_length > MAX_LEN) ? MAX_LEN : item.code_length;

    // Table memory: one write port for loads, one registered read for lookups.
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && sym_ok)
        begin
            mem[addr] <= {item.code_value[MAX_CODE_BITS-1:0], len_sat};
        end
        if (cmd.lookup)
        begin
            {rd_code_reg, rd_len_reg} <= mem[addr];
            rd_ok_reg                 <= sym_ok;
        end
    end

    // The top byte of the left-aligned code is dropped into the free bits.
    assign chunk       = aligned_reg[MAX_CODE_BITS-1 -: BYTE_BITS];
    assign right_shift = BYTE_USED - free_reg;
    assign placed      = chunk >> right_shift;
    assign byte_val    = partial_reg | placed;
    assign rem_after   = rem_reg - LEN_W'(free_reg);
    assign fills       = rem_reg >= LEN_W'(free_reg);
    assign pending     = free_reg != BYTE_USED;
    assign out_taken   = out_valid_reg && !result_stall;
    assign out_ready   = !out_valid_reg || !result_stall;

    always_comb
    begin
        aligned_next   = aligned_reg;
        rem_next       = rem_reg;
        partial_next   = partial_reg;
        free_next      = free_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_taken;

        if (cmd.align)
        begin
            aligned_next = rd_code_reg << (MAX_LEN - rd_len_reg);
            rem_next     = rd_ok_reg ? rd_len_reg : '0;
        end

        if (cmd.step)
        begin
            if (fills)
            begin
                out_next.out_byte  = byte_val;
                out_next.bits_used = BYTE_USED;
                // Another full byte follows only if a whole byte of code remains.
                out_next.last      = rem_after < BYTE_LEN;
                out_valid_next     = 1'b1;
                aligned_next       = aligned_reg << free_reg;
                rem_next           = rem_after;
                partial_next       = '0;
                free_next          = BYTE_USED;
            end
            else
            begin
                partial_next = byte_val;
                free_next    = free_reg - rem_reg[USED_W-1:0];
                rem_next     = '0;
            end
        end

        if (cmd.flush)
        begin
            if (pending)
            begin
                out_next.out_byte  = partial_reg;
                out_next.bits_used = BYTE_USED - free_reg;
                out_next.last      = 1'b1;
                out_valid_next     = 1'b1;
            end
            partial_next = '0;
            free_next    = BYTE_USED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            partial_reg   <= '0;
            free_reg      <= BYTE_USED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            partial_reg   <= partial_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        aligned_reg <= aligned_next;
        out_reg     <= out_next;
    end

    assign status.rem_zero  = rem_reg == '0;
    assign status.fills     = fills;
    assign status.pending   = pending;
    assign status.out_ready = out_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

>>> src/hcbp_ctrl.sv
// Controller of the bit packer: sequences table loads, lookups, packing steps
// and flushes. Depends on hcbp_pkg; drives hcbp_datapath through cmd_t.
`default_nettype none

module hcbp_ctrl
    import hcbp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire logic [KIND_W-1:0] item_kind,
    input  wire status_t           status,
    output cmd_t                   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ALIGN = 4'b0010,
        ST_PACK  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = state_reg != ST_IDLE;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (item_kind)
                        KIND_LOAD:
                        begin
                            cmd.load_wr = 1'b1;
                        end
                        KIND_ENCODE:
                        begin
                            cmd.lookup = 1'b1;
                            state_next = ST_ALIGN;
                        end
                        KIND_FLUSH:
                        begin
                            state_next = ST_FLUSH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ALIGN:
            begin
                cmd.align  = 1'b1;
                state_next = ST_PACK;
            end
            ST_PACK:
            begin
                // A step that completes a byte must wait for the result register.
                if (status.rem_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if (!status.fills)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.out_ready)
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (!status.pending || status.out_ready)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
